>>> rtl/i2c_master_buffer_sequencer_assert.svh
// ----------------------------------------------------------------------------
// I2C master buffer sequencer assertion macros
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BUFFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BUFFER_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define I2CMBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define I2CMBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define I2CMBS_ASSERT_SAME(label, ante, cons)

`define I2CMBS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master buffer sequencer package
// Item layouts, opcodes, host status and error codes, bus status codes.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    localparam int DEF_BUF_DEPTH = 16;
    localparam int CMP_W         = 9;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [2:0] ST_READY  = 3'd0;
    localparam logic [2:0] ST_BUSY   = 3'd1;
    localparam logic [2:0] ST_TXDONE = 3'd2;
    localparam logic [2:0] ST_RXDONE = 3'd3;
    localparam logic [2:0] ST_ERROR  = 3'd4;

    localparam logic [2:0] EK_NONE = 3'd0;
    localparam logic [2:0] EK_OVF  = 3'd1;
    localparam logic [2:0] EK_NORX = 3'd2;
    localparam logic [2:0] EK_ARB  = 3'd3;
    localparam logic [2:0] EK_BUS  = 3'd4;

    localparam logic [7:0] BS_START    = 8'h08;
    localparam logic [7:0] BS_RESTART  = 8'h10;
    localparam logic [7:0] BS_ADDR_ACK = 8'h18;
    localparam logic [7:0] BS_DATA_ACK = 8'h28;
    localparam logic [7:0] BS_ARB_LOST = 8'h38;
    localparam logic [7:0] BS_RADDR_ACK = 8'h40;
    localparam logic [7:0] BS_RX_ACK   = 8'h50;
    localparam logic [7:0] BS_RX_NACK  = 8'h58;

    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] rx_byte;
        logic [7:0] bus_status;
        logic [7:0] xfer_count;
        logic [7:0] load_value;
        logic [3:0] slot;
    } in_data_t;

    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] read_byte;
        logic [7:0] error_code;
        logic [2:0] error_kind;
        logic [2:0] host_status;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       cmd_int_enable;
        logic       cmd_enable;
        logic       cmd_ack;
        logic       cmd_stop;
        logic       cmd_start;
        logic       cmd_valid;
    } res_t;

endpackage

>>> rtl/i2c_master_buffer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master buffer sequencer
// Buffered command sequencer that sits above a byte-level I2C bus engine.
// ----------------------------------------------------------------------------
//  Port group   Direction  Carries
//  s_*          in         one host command or bus status event per item
//  m_*          out        one engine command and host status per item
//
//  An accepted item is held in the input register until its result moves to the
//  output register; one item can be accepted every cycle barring a stall.
//  Reset clears the sequencer state and both valid flags; buffer contents
//  are undefined until written.
//  A stalled result holds the input register, and s_tready drops only
//  while both registers are full and m_tready is low.
// ----------------------------------------------------------------------------
module i2c_master_buffer_sequencer #(
    parameter int BUF_DEPTH = i2cmbs_pkg::DEF_BUF_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot, load_value, xfer_count, bus_status, rx_byte, zero pad
    input  logic [39:0] s_tdata,
    // opcode
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cmd_valid, cmd_start, cmd_stop, cmd_ack, cmd_enable, cmd_int_enable,
    // tx_valid, tx_byte, host_status, error_kind, error_code, read_byte, zero pad
    output logic [39:0] m_tdata
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = $clog2(BUF_DEPTH + 1);

    i2cmbs_pkg::in_data_t s_in;
    i2cmbs_pkg::in_data_t stage_data_reg;
    logic [1:0]           stage_op_reg;
    logic                 stage_last_reg;
    logic                 stage_valid_reg;
    logic                 m_valid_reg;
    i2cmbs_pkg::res_t     m_data_reg;
    i2cmbs_pkg::res_t     res;
    logic                 advance;
    logic                 s_fire;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic [PW-1:0]        rd_ptr;

    assign s_in     = i2cmbs_pkg::in_data_t'(s_tdata);
    assign advance  = stage_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        if (s_tuser == i2cmbs_pkg::OP_FETCH) begin
            rd_addr = AW'(i2cmbs_pkg::CMP_W'(s_in.slot) + 9'd1);
        end else if ((s_tuser == i2cmbs_pkg::OP_EVENT) &&
                     ((s_in.bus_status == i2cmbs_pkg::BS_START) ||
                      (s_in.bus_status == i2cmbs_pkg::BS_RESTART))) begin
            rd_addr = '0;
        end else begin
            rd_addr = AW'(rd_ptr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_fire) begin
            stage_valid_reg <= 1'b1;
        end else if (advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stage_data_reg <= s_in;
            stage_op_reg   <= s_tuser;
            stage_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res;
        end
    end

    i2cmbs_buffer #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    i2cmbs_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .PW        (PW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .opcode     (stage_op_reg),
        .fetch_last (stage_last_reg),
        .item       (stage_data_reg),
        .rd_data    (rd_data),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_ptr     (rd_ptr)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`include "i2c_master_buffer_sequencer_assert.svh"

    `I2CMBS_ASSERT_SAME(a_tx_needs_cmd, m_valid_reg && m_data_reg.tx_valid,
        m_data_reg.cmd_valid && m_data_reg.cmd_int_enable && !m_data_reg.cmd_stop)
    `I2CMBS_ASSERT_SAME(a_arb_while_busy,
        m_valid_reg && (m_data_reg.error_kind == i2cmbs_pkg::EK_ARB),
        m_data_reg.host_status == i2cmbs_pkg::ST_BUSY)
    `I2CMBS_ASSERT_SAME(a_full_stall, stage_valid_reg && m_valid_reg && !m_tready,
        !s_tready)
    `I2CMBS_ASSERT_NEXT(a_stall_holds_stage, stage_valid_reg && !advance,
        stage_valid_reg && $stable(stage_data_reg) && $stable(stage_op_reg))

endmodule

>>> rtl/i2cmbs_buffer.sv
// ----------------------------------------------------------------------------
// I2C master buffer sequencer message buffer
// One write port and one registered read port with write-to-read bypass.
// ----------------------------------------------------------------------------
module i2cmbs_buffer #(
    parameter int BUF_DEPTH = i2cmbs_pkg::DEF_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/i2cmbs_ctrl.sv
// ----------------------------------------------------------------------------
// I2C master buffer sequencer control
// Decodes one item against the sequencer state and forms its result.
// ----------------------------------------------------------------------------
module i2cmbs_ctrl #(
    parameter int BUF_DEPTH = i2cmbs_pkg::DEF_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH),
    parameter int PW        = $clog2(BUF_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [1:0]           opcode,
    input  logic                 fetch_last,
    input  i2cmbs_pkg::in_data_t item,
    input  logic [7:0]           rd_data,
    output i2cmbs_pkg::res_t     res,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic [PW-1:0]        rd_ptr
);

    localparam logic [i2cmbs_pkg::CMP_W-1:0] DEPTH_C = i2cmbs_pkg::CMP_W'(BUF_DEPTH);

    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [PW-1:0] count_reg;
    logic [PW-1:0] count_next;
    logic [2:0]    status_reg;
    logic [2:0]    status_next;
    logic [2:0]    ekind_reg;
    logic [2:0]    ekind_next;
    logic [7:0]    ecode_reg;
    logic [7:0]    ecode_next;
    logic [PW-1:0] tx_ptr;
    logic          wr_hit;

    always_comb begin
        res         = '0;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        ekind_next  = ekind_reg;
        ecode_next  = ecode_reg;
        wr_hit      = 1'b0;
        wr_addr     = ptr_reg[AW-1:0];
        wr_data     = item.rx_byte;
        if ((item.bus_status == i2cmbs_pkg::BS_START) ||
            (item.bus_status == i2cmbs_pkg::BS_RESTART)) begin
            tx_ptr = '0;
        end else begin
            tx_ptr = ptr_reg;
        end
        case (opcode)
            i2cmbs_pkg::OP_LOAD: begin
                if ((status_reg != i2cmbs_pkg::ST_BUSY) &&
                    (i2cmbs_pkg::CMP_W'(item.slot) < DEPTH_C)) begin
                    wr_hit  = 1'b1;
                    wr_addr = AW'(item.slot);
                    wr_data = item.load_value;
                end
            end
            i2cmbs_pkg::OP_START: begin
                if (status_reg != i2cmbs_pkg::ST_BUSY) begin
                    if (i2cmbs_pkg::CMP_W'(item.xfer_count) <= DEPTH_C) begin
                        count_next         = PW'(item.xfer_count);
                        status_next        = i2cmbs_pkg::ST_BUSY;
                        ekind_next         = i2cmbs_pkg::EK_NONE;
                        ecode_next         = '0;
                        res.cmd_valid      = 1'b1;
                        res.cmd_start      = 1'b1;
                        res.cmd_ack        = 1'b1;
                        res.cmd_enable     = 1'b1;
                        res.cmd_int_enable = 1'b1;
                    end else begin
                        status_next = i2cmbs_pkg::ST_ERROR;
                        ekind_next  = i2cmbs_pkg::EK_OVF;
                        ecode_next  = '0;
                    end
                end
            end
            i2cmbs_pkg::OP_EVENT: begin
                if (status_reg == i2cmbs_pkg::ST_BUSY) begin
                    res.cmd_valid = 1'b1;
                    case (item.bus_status)
                        i2cmbs_pkg::BS_START, i2cmbs_pkg::BS_RESTART,
                        i2cmbs_pkg::BS_ADDR_ACK, i2cmbs_pkg::BS_DATA_ACK: begin
                            res.cmd_enable = 1'b1;
                            if (tx_ptr >= count_reg) begin
                                ptr_next    = tx_ptr;
                                status_next = i2cmbs_pkg::ST_TXDONE;
                                ekind_next  = i2cmbs_pkg::EK_NONE;
                                ecode_next  = '0;
                                res.cmd_stop = 1'b1;
                            end else begin
                                ptr_next           = tx_ptr + PW'(1);
                                res.tx_valid       = 1'b1;
                                res.tx_byte        = rd_data;
                                res.cmd_int_enable = 1'b1;
                            end
                        end
                        i2cmbs_pkg::BS_RX_ACK: begin
                            if (i2cmbs_pkg::CMP_W'(ptr_reg) < DEPTH_C) begin
                                wr_hit   = 1'b1;
                                ptr_next = ptr_reg + PW'(1);
                            end
                            res.cmd_ack        = (ptr_next < count_reg);
                            res.cmd_enable     = 1'b1;
                            res.cmd_int_enable = 1'b1;
                        end
                        i2cmbs_pkg::BS_RADDR_ACK: begin
                            res.cmd_ack        = (ptr_reg < count_reg);
                            res.cmd_enable     = 1'b1;
                            res.cmd_int_enable = 1'b1;
                        end
                        i2cmbs_pkg::BS_RX_NACK: begin
                            wr_hit         = (i2cmbs_pkg::CMP_W'(ptr_reg) < DEPTH_C);
                            status_next    = i2cmbs_pkg::ST_RXDONE;
                            ekind_next     = i2cmbs_pkg::EK_NONE;
                            ecode_next     = '0;
                            res.cmd_stop   = 1'b1;
                            res.cmd_enable = 1'b1;
                        end
                        i2cmbs_pkg::BS_ARB_LOST: begin
                            ekind_next         = i2cmbs_pkg::EK_ARB;
                            ecode_next         = item.bus_status;
                            res.cmd_start      = 1'b1;
                            res.cmd_enable     = 1'b1;
                            res.cmd_int_enable = 1'b1;
                        end
                        default: begin
                            status_next  = i2cmbs_pkg::ST_ERROR;
                            ekind_next   = i2cmbs_pkg::EK_BUS;
                            ecode_next   = item.bus_status + 8'd1;
                            res.cmd_stop = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                if (status_reg == i2cmbs_pkg::ST_RXDONE) begin
                    if ((i2cmbs_pkg::CMP_W'(item.slot) + 9'd1) < DEPTH_C) begin
                        res.read_byte = rd_data;
                    end
                    if (fetch_last) begin
                        status_next = i2cmbs_pkg::ST_READY;
                    end
                end else if (status_reg == i2cmbs_pkg::ST_TXDONE) begin
                    ekind_next = i2cmbs_pkg::EK_NORX;
                    ecode_next = '0;
                end
            end
        endcase
        res.host_status = status_next;
        res.error_kind  = ekind_next;
        res.error_code  = ecode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            count_reg  <= '0;
            status_reg <= i2cmbs_pkg::ST_READY;
            ekind_reg  <= i2cmbs_pkg::EK_NONE;
            ecode_reg  <= '0;
        end else if (advance) begin
            ptr_reg    <= ptr_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            ekind_reg  <= ekind_next;
            ecode_reg  <= ecode_next;
        end
    end

    assign wr_en  = advance && wr_hit;
    assign rd_ptr = advance ? ptr_next : ptr_reg;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// I2C master buffer sequencer testbench
// Drives host commands and bus status events into the sequencer. A scoreboard
// class predicts each result item from its own copy of the buffer and status,
// and compares every result item field by field. Sender gaps and receiver
// stalls vary by phase, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = i2cmbs_pkg::DEF_BUF_DEPTH;
    localparam int PHASE_ITEMS = 300;
    localparam int CYCLE_LIMIT = 500000;

    class seq_scoreboard;
        logic [7:0]       msg_bytes [DEPTH];
        int               ptr;
        int               count;
        logic [2:0]       status;
        logic [2:0]       err_kind;
        logic [7:0]       err_code;
        i2cmbs_pkg::res_t expected_q [$];
        int               mismatches;

        function new();
            foreach (msg_bytes[i]) msg_bytes[i] = 8'h00;
            ptr        = 0;
            count      = 0;
            status     = i2cmbs_pkg::ST_READY;
            err_kind   = i2cmbs_pkg::EK_NONE;
            err_code   = 8'h00;
            mismatches = 0;
        endfunction

        function void set_cmd(inout i2cmbs_pkg::res_t r, input bit st, sp, ak, en, ie);
            r.cmd_valid      = 1'b1;
            r.cmd_start      = st;
            r.cmd_stop       = sp;
            r.cmd_ack        = ak;
            r.cmd_enable     = en;
            r.cmd_int_enable = ie;
        endfunction

        function void clear_error();
            err_kind = i2cmbs_pkg::EK_NONE;
            err_code = 8'h00;
        endfunction

        function void send_next_byte(inout i2cmbs_pkg::res_t r);
            if (ptr >= count) begin
                status = i2cmbs_pkg::ST_TXDONE;
                clear_error();
                set_cmd(r, 0, 1, 0, 1, 0);
            end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = msg_bytes[ptr];
                ptr++;
                set_cmd(r, 0, 0, 0, 1, 1);
            end
        endfunction

        function void apply_status_event(inout i2cmbs_pkg::res_t r,
                                         input logic [7:0] code,
                                         input logic [7:0] rx);
            case (code)
                i2cmbs_pkg::BS_START, i2cmbs_pkg::BS_RESTART: begin
                    ptr = 0;
                    send_next_byte(r);
                end
                i2cmbs_pkg::BS_ADDR_ACK, i2cmbs_pkg::BS_DATA_ACK: begin
                    send_next_byte(r);
                end
                i2cmbs_pkg::BS_RX_ACK: begin
                    if (ptr < DEPTH) begin
                        msg_bytes[ptr] = rx;
                        ptr++;
                    end
                    set_cmd(r, 0, 0, ptr < count, 1, 1);
                end
                i2cmbs_pkg::BS_RADDR_ACK: begin
                    set_cmd(r, 0, 0, ptr < count, 1, 1);
                end
                i2cmbs_pkg::BS_RX_NACK: begin
                    if (ptr < DEPTH) msg_bytes[ptr] = rx;
                    status = i2cmbs_pkg::ST_RXDONE;
                    clear_error();
                    set_cmd(r, 0, 1, 0, 1, 0);
                end
                i2cmbs_pkg::BS_ARB_LOST: begin
                    err_kind = i2cmbs_pkg::EK_ARB;
                    err_code = code;
                    set_cmd(r, 1, 0, 0, 1, 1);
                end
                default: begin
                    status   = i2cmbs_pkg::ST_ERROR;
                    err_kind = i2cmbs_pkg::EK_BUS;
                    err_code = code + 8'd1;
                    set_cmd(r, 0, 1, 0, 0, 0);
                end
            endcase
        endfunction

        function void note_item(logic [1:0] op, i2cmbs_pkg::in_data_t d, bit last);
            i2cmbs_pkg::res_t r;
            r = '0;
            case (op)
                i2cmbs_pkg::OP_LOAD: begin
                    if (status != i2cmbs_pkg::ST_BUSY) msg_bytes[d.slot] = d.load_value;
                end
                i2cmbs_pkg::OP_START: begin
                    if (status != i2cmbs_pkg::ST_BUSY) begin
                        if (d.xfer_count <= DEPTH) begin
                            count  = d.xfer_count;
                            status = i2cmbs_pkg::ST_BUSY;
                            clear_error();
                            set_cmd(r, 1, 0, 1, 1, 1);
                        end else begin
                            status   = i2cmbs_pkg::ST_ERROR;
                            err_kind = i2cmbs_pkg::EK_OVF;
                            err_code = 8'h00;
                        end
                    end
                end
                i2cmbs_pkg::OP_EVENT: begin
                    if (status == i2cmbs_pkg::ST_BUSY)
                        apply_status_event(r, d.bus_status, d.rx_byte);
                end
                default: begin
                    if (status == i2cmbs_pkg::ST_RXDONE) begin
                        r.read_byte = (d.slot + 1 < DEPTH) ? msg_bytes[d.slot + 1] : 8'h00;
                        if (last) status = i2cmbs_pkg::ST_READY;
                    end else if (status == i2cmbs_pkg::ST_TXDONE) begin
                        err_kind = i2cmbs_pkg::EK_NORX;
                        err_code = 8'h00;
                    end
                end
            endcase
            r.host_status = status;
            r.error_kind  = err_kind;
            r.error_code  = err_code;
            expected_q.push_back(r);
        endfunction

        function void check_result(i2cmbs_pkg::res_t g);
            string            diff;
            i2cmbs_pkg::res_t e;
            diff = "";
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", g);
                return;
            end
            e = expected_q.pop_front();
            if (g.cmd_valid !== e.cmd_valid) diff = {diff, " cmd_valid"};
            if (g.cmd_start !== e.cmd_start) diff = {diff, " cmd_start"};
            if (g.cmd_stop !== e.cmd_stop) diff = {diff, " cmd_stop"};
            if (g.cmd_ack !== e.cmd_ack) diff = {diff, " cmd_ack"};
            if (g.cmd_enable !== e.cmd_enable) diff = {diff, " cmd_enable"};
            if (g.cmd_int_enable !== e.cmd_int_enable) diff = {diff, " cmd_int_enable"};
            if (g.tx_valid !== e.tx_valid) diff = {diff, " tx_valid"};
            if (g.tx_byte !== e.tx_byte) diff = {diff, " tx_byte"};
            if (g.host_status !== e.host_status) diff = {diff, " host_status"};
            if (g.error_kind !== e.error_kind) diff = {diff, " error_kind"};
            if (g.error_code !== e.error_code) diff = {diff, " error_code"};
            if (g.read_byte !== e.read_byte) diff = {diff, " read_byte"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s: expected %h actual %h", diff, e, g);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    i2cmbs_pkg::in_data_t s_tdata  = '0;
    logic [1:0]           s_tuser  = i2cmbs_pkg::OP_LOAD;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    i2cmbs_pkg::res_t     m_tdata;

    seq_scoreboard sb = new();
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycles        = 0;

    i2c_master_buffer_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic i2cmbs_pkg::in_data_t rnd_item();
        logic [63:0]          w;
        i2cmbs_pkg::in_data_t d;
        w     = {$urandom, $urandom};
        d     = w[39:0];
        d.pad = '0;
        return d;
    endfunction

    task automatic send(logic [1:0] op, i2cmbs_pkg::in_data_t d, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, d, last);
        items_sent++;
    endtask

    task automatic load_byte(int slot, int val);
        i2cmbs_pkg::in_data_t d;
        d            = rnd_item();
        d.slot       = 4'(slot);
        d.load_value = 8'(val);
        send(i2cmbs_pkg::OP_LOAD, d, 1'($urandom_range(1)));
    endtask

    task automatic start_xfer(int n);
        i2cmbs_pkg::in_data_t d;
        d            = rnd_item();
        d.xfer_count = 8'(n);
        send(i2cmbs_pkg::OP_START, d, 1'($urandom_range(1)));
    endtask

    task automatic post_status(logic [7:0] code, int rx);
        i2cmbs_pkg::in_data_t d;
        d            = rnd_item();
        d.bus_status = code;
        d.rx_byte    = 8'(rx);
        send(i2cmbs_pkg::OP_EVENT, d, 1'($urandom_range(1)));
    endtask

    task automatic fetch_byte(int slot, bit last);
        i2cmbs_pkg::in_data_t d;
        d      = rnd_item();
        d.slot = 4'(slot);
        send(i2cmbs_pkg::OP_FETCH, d, last);
    endtask

    function automatic logic [7:0] error_status();
        logic [7:0] codes [6] = '{8'h00, 8'h20, 8'h30, 8'h48, 8'hF8, 8'hFF};
        return codes[$urandom_range(5)];
    endfunction

    task automatic end_busy();
        while (sb.status == i2cmbs_pkg::ST_BUSY) post_status(error_status(), $urandom);
    endtask

    task automatic write_msg();
        int n;
        int k;
        n = $urandom_range(3);
        end_busy();
        repeat (n) load_byte($urandom_range(DEPTH - 1), $urandom);
        start_xfer(($urandom_range(8) == 0) ? DEPTH : $urandom_range(6));
        post_status(i2cmbs_pkg::BS_START, $urandom);
        k = 0;
        while (sb.status == i2cmbs_pkg::ST_BUSY && k < 40) begin
            case ($urandom_range(39))
                0, 1:    post_status(i2cmbs_pkg::BS_ARB_LOST, $urandom);
                2:       post_status(i2cmbs_pkg::BS_RESTART, $urandom);
                3:       post_status(error_status(), $urandom);
                default: post_status((k == 0) ? i2cmbs_pkg::BS_ADDR_ACK
                                              : i2cmbs_pkg::BS_DATA_ACK, $urandom);
            endcase
            k++;
        end
        if ($urandom_range(3) == 0)
            fetch_byte($urandom_range(DEPTH - 1), 1'($urandom_range(1)));
    endtask

    task automatic read_msg();
        int c;
        int m;
        int nrx;
        end_busy();
        c = ($urandom_range(5) == 0) ? DEPTH : $urandom_range(1, 6);
        m = c - 1 + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
        start_xfer(c);
        post_status(i2cmbs_pkg::BS_START, $urandom);
        post_status(i2cmbs_pkg::BS_RADDR_ACK, $urandom);
        for (int i = 0; i < m; i++) begin
            if ($urandom_range(29) == 0) post_status(i2cmbs_pkg::BS_ARB_LOST, $urandom);
            post_status(i2cmbs_pkg::BS_RX_ACK, $urandom);
        end
        post_status(i2cmbs_pkg::BS_RX_NACK, $urandom);
        if ($urandom_range(4) == 0) return;
        nrx = (m + 1 > DEPTH - 1) ? DEPTH - 1 : m + 1;
        if ($urandom_range(3) == 0) fetch_byte(DEPTH - 1, 1'b0);
        for (int i = 0; i < nrx; i++) fetch_byte(i, i == nrx - 1);
    endtask

    task automatic noise_burst();
        i2cmbs_pkg::in_data_t d;
        repeat ($urandom_range(1, 4)) begin
            d = rnd_item();
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(7))
                    0: d.bus_status = i2cmbs_pkg::BS_START;
                    1: d.bus_status = i2cmbs_pkg::BS_RESTART;
                    2: d.bus_status = i2cmbs_pkg::BS_ADDR_ACK;
                    3: d.bus_status = i2cmbs_pkg::BS_DATA_ACK;
                    4: d.bus_status = i2cmbs_pkg::BS_ARB_LOST;
                    5: d.bus_status = i2cmbs_pkg::BS_RADDR_ACK;
                    6: d.bus_status = i2cmbs_pkg::BS_RX_ACK;
                    default: d.bus_status = i2cmbs_pkg::BS_RX_NACK;
                endcase
            end
            send(2'($urandom_range(3)), d, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit hold_off);
        int target;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        if (hold_off) hold_left <= 400;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3: write_msg();
                4, 5, 6, 7: read_msg();
                default:    noise_burst();
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The whole buffer is written first so that no transfer reads an unwritten entry.
        for (int i = 0; i < DEPTH; i++)
            load_byte(i, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : {i[3:0], ~i[3:0]});

        post_status(i2cmbs_pkg::BS_ADDR_ACK, 8'h00);
        start_xfer(8'hFF);
        start_xfer(DEPTH + 1);
        start_xfer(8'd2);
        load_byte(3, 8'h77);
        start_xfer(8'd4);
        post_status(i2cmbs_pkg::BS_START, 8'h00);
        post_status(i2cmbs_pkg::BS_ARB_LOST, 8'hFF);
        post_status(i2cmbs_pkg::BS_RESTART, 8'h00);
        post_status(i2cmbs_pkg::BS_ADDR_ACK, 8'h00);
        post_status(i2cmbs_pkg::BS_DATA_ACK, 8'h00);
        fetch_byte(0, 1'b1);
        start_xfer(DEPTH);
        post_status(i2cmbs_pkg::BS_START, 8'h00);
        post_status(i2cmbs_pkg::BS_RADDR_ACK, 8'h00);
        post_status(i2cmbs_pkg::BS_RX_ACK, 8'hFF);
        post_status(i2cmbs_pkg::BS_RX_NACK, 8'h00);
        fetch_byte(0, 1'b0);
        fetch_byte(DEPTH - 1, 1'b1);
        fetch_byte(1, 1'b1);
        start_xfer(8'd0);
        post_status(8'h20, 8'h00);
        post_status(i2cmbs_pkg::BS_START, 8'h00);
        start_xfer(8'd1);
        post_status(8'hFF, 8'hFF);

        run_phase(0, 0, 1'b1);
        run_phase(88, 0, 1'b0);
        run_phase(0, 88, 1'b0);
        run_phase(30, 30, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        sb.mismatches += sb.expected_q.size();
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/i2cmbs_pkg.sv
rtl/i2cmbs_buffer.sv
rtl/i2cmbs_ctrl.sv
rtl/i2c_master_buffer_sequencer.sv
dv/tb_top.sv
